/* src/rrts_pkg.sv */
// Shared types, codes and reset constants of the round robin task scheduler.
package rrts_pkg;

    localparam int MAX_TASKS_DEF = 16;

    localparam logic [15:0] SLICE_RESET    = 16'd100;
    localparam logic [9:0]  MPT_RESET      = 10'd10;
    localparam logic [15:0] PID_SLOT0      = 16'd1;
    localparam logic [15:0] NEXT_PID_RESET = 16'd2;

    localparam logic [1:0] CMD_TICK    = 2'd0;
    localparam logic [1:0] CMD_CREATE  = 2'd1;
    localparam logic [1:0] CMD_SIG_PID = 2'd2;
    localparam logic [1:0] CMD_SIG_CUR = 2'd3;

    localparam logic [2:0] SIG_SEGFAULT = 3'd3;
    localparam logic [2:0] SIG_STOP     = 3'd4;
    localparam logic [2:0] SIG_CONT     = 3'd5;

    localparam logic [1:0] TS_RUNNING = 2'd0;
    localparam logic [1:0] TS_ZOMBIE  = 2'd1;
    localparam logic [1:0] TS_PAUSED  = 2'd3;

    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_NO_PID = 2'd1;
    localparam logic [1:0] STAT_FULL   = 2'd2;

    localparam logic REG_SLICE = 1'b0;
    localparam logic REG_MPT   = 1'b1;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [2:0]  signal_code;
        logic [15:0] target_pid;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  running_slot;
        logic [15:0] running_pid;
        logic        switched;
        logic [15:0] new_pid;
        logic [1:0]  status;
    } t_out_item;

    typedef struct packed {
        logic [15:0] slice_length_ms;
        logic [9:0]  ms_per_tick;
    } t_cfg;

    function automatic logic [1:0] apply_signal(input logic [1:0] old_state,
                                                input logic [2:0] code);
        logic [1:0] res;
        res = old_state;
        if (code <= SIG_SEGFAULT) begin
            res = TS_ZOMBIE;
        end else if (code == SIG_STOP) begin
            res = TS_PAUSED;
        end else if (code == SIG_CONT) begin
            res = TS_RUNNING;
        end
        return res;
    endfunction

endpackage

/* src/round_robin_task_scheduler.sv */
// Top level of the round robin task scheduler with its configuration port.
// A tick that does not end the slice, and a signal to the current task, need no scan of the
// table; a switching tick, a create and a signal to a pid have the sequencer examine the
// slots one at a time, and a signal to a pid reads each slot's pid from the RAM first.
// Busy stays high until the result beat is shown, and the receiver cannot stall it.
// Reset is synchronous and restores the task table.
module round_robin_task_scheduler import rrts_pkg::*; #(
    parameter int MAX_TASKS = MAX_TASKS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_in_item    i_item,
    output logic        o_strobe,
    output t_out_item   o_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg cfg;
    logic accept;

    assign accept = start && !busy;

    rrts_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    rrts_ctrl #(
        .MAX_TASKS (MAX_TASKS)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (accept),
        .i_item   (i_item),
        .i_cfg    (cfg),
        .o_busy   (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("busy not raised after an accepted start");

    a_single_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result beat held longer than one cycle");

    a_full_no_pid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.status == STAT_FULL) |-> (o_result.new_pid == 16'd0))
        else $error("full table reported with a new pid");

    a_switch_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.switched) |-> (o_result.status == STAT_OK))
        else $error("switch reported with an error status");

endmodule

/* src/rrts_ram.sv */
// Generic single write port, single read port RAM with registered read data.
module rrts_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/rrts_cfg.sv */
// APB configuration registers of the round robin task scheduler.
module rrts_cfg import rrts_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    logic [15:0] r_slice_len;
    logic [9:0]  r_mpt;
    logic        wr_en;
    logic        reg_sel;

    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slice_len <= SLICE_RESET;
            r_mpt       <= MPT_RESET;
        end else if (wr_en) begin
            case (reg_sel)
                REG_SLICE: r_slice_len <= pwdata[15:0];
                REG_MPT:   r_mpt       <= pwdata[9:0];
                default:   r_mpt       <= r_mpt;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_SLICE: prdata = {16'd0, r_slice_len};
            REG_MPT:   prdata = {22'd0, r_mpt};
            default:   prdata = 32'd0;
        endcase
    end

    assign pready                = 1'b1;
    assign o_cfg.slice_length_ms = r_slice_len;
    assign o_cfg.ms_per_tick     = r_mpt;

endmodule

/* src/rrts_ctrl.sv */
// Task table and the sequencer that examines its slots one at a time.
module rrts_ctrl import rrts_pkg::*; #(
    parameter int MAX_TASKS = MAX_TASKS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output logic      o_busy,
    output logic      o_strobe,
    output t_out_item o_result
);

    localparam int IW = $clog2(MAX_TASKS);
    localparam logic [IW-1:0] LAST = IW'(MAX_TASKS - 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_TICK   = 4'd1;
    localparam logic [3:0] S_ZSCAN  = 4'd2;
    localparam logic [3:0] S_RSCAN  = 4'd3;
    localparam logic [3:0] S_CREATE = 4'd4;
    localparam logic [3:0] S_PREQ   = 4'd5;
    localparam logic [3:0] S_PCMP   = 4'd6;
    localparam logic [3:0] S_SIGCUR = 4'd7;
    localparam logic [3:0] S_RDPID  = 4'd8;
    localparam logic [3:0] S_DONE   = 4'd9;

    logic [3:0]           r_fsm, n_fsm;
    logic [MAX_TASKS-1:0] r_used, n_used;
    logic [1:0]           r_tstate [MAX_TASKS];
    logic [1:0]           n_tstate [MAX_TASKS];
    logic [IW-1:0]        r_cur, n_cur;
    logic [IW-1:0]        r_idx, n_idx;
    logic [IW-1:0]        r_cnt, n_cnt;
    logic [16:0]          r_slice, n_slice;
    logic [15:0]          r_next_pid, n_next_pid;
    logic [2:0]           r_code, n_code;
    logic [15:0]          r_pid, n_pid;
    logic                 r_sw, n_sw;
    logic [15:0]          r_new_pid, n_new_pid;
    logic [1:0]           r_status, n_status;
    logic                 r_strobe, n_strobe;
    t_out_item            r_result, n_result;

    logic                 mem_we;
    logic [IW-1:0]        mem_raddr;
    logic [15:0]          mem_rdata;
    logic [15:0]          slot_pid;
    logic [IW-1:0]        idx_inc;
    logic [IW-1:0]        cur_inc;

    rrts_ram #(
        .WIDTH (16),
        .DEPTH (MAX_TASKS)
    ) u_pid_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_idx),
        .i_wdata (r_next_pid),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign mem_raddr = (r_fsm == S_PREQ) ? r_idx : r_cur;
    assign idx_inc   = (r_idx == LAST) ? '0 : r_idx + 1'b1;
    assign cur_inc   = (r_cur == LAST) ? '0 : r_cur + 1'b1;
    assign slot_pid  = (mem_raddr == '0) ? PID_SLOT0 : mem_rdata;

    always_comb begin
        n_fsm      = r_fsm;
        n_used     = r_used;
        n_tstate   = r_tstate;
        n_cur      = r_cur;
        n_idx      = r_idx;
        n_cnt      = r_cnt;
        n_slice    = r_slice;
        n_next_pid = r_next_pid;
        n_code     = r_code;
        n_pid      = r_pid;
        n_sw       = r_sw;
        n_new_pid  = r_new_pid;
        n_status   = r_status;
        n_strobe   = 1'b0;
        n_result   = r_result;
        mem_we     = 1'b0;
        case (r_fsm)
            S_IDLE: begin
                if (i_start) begin
                    n_code    = i_item.signal_code;
                    n_pid     = i_item.target_pid;
                    n_sw      = 1'b0;
                    n_new_pid = 16'd0;
                    n_status  = STAT_OK;
                    n_idx     = '0;
                    case (i_item.cmd)
                        CMD_TICK:    n_fsm = S_TICK;
                        CMD_CREATE:  n_fsm = S_CREATE;
                        CMD_SIG_PID: n_fsm = S_PREQ;
                        default:     n_fsm = S_SIGCUR;
                    endcase
                end
            end
            S_TICK: begin
                if (r_slice < {1'b0, i_cfg.slice_length_ms}) begin
                    n_slice = r_slice + {7'd0, i_cfg.ms_per_tick};
                    n_fsm   = S_RDPID;
                end else begin
                    n_slice = '0;
                    n_idx   = IW'(1);
                    n_fsm   = S_ZSCAN;
                end
            end
            S_ZSCAN: begin
                if ((r_used[r_idx] && r_tstate[r_idx] == TS_ZOMBIE) || r_idx == LAST) begin
                    if (r_used[r_idx] && r_tstate[r_idx] == TS_ZOMBIE) begin
                        n_used[r_idx] = 1'b0;
                    end
                    n_idx = cur_inc;
                    n_cnt = IW'(1);
                    n_fsm = S_RSCAN;
                end else begin
                    n_idx = idx_inc;
                end
            end
            S_RSCAN: begin
                if (r_used[r_idx] && r_tstate[r_idx] == TS_RUNNING) begin
                    n_cur = r_idx;
                    n_sw  = 1'b1;
                    n_fsm = S_RDPID;
                end else if (r_cnt == LAST) begin
                    n_fsm = S_RDPID;
                end else begin
                    n_idx = idx_inc;
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_CREATE: begin
                if (!r_used[r_idx]) begin
                    n_used[r_idx]   = 1'b1;
                    n_tstate[r_idx] = TS_RUNNING;
                    mem_we          = 1'b1;
                    n_new_pid       = r_next_pid;
                    n_next_pid      = r_next_pid + 16'd1;
                    n_fsm           = S_RDPID;
                end else if (r_idx == LAST) begin
                    n_status = STAT_FULL;
                    n_fsm    = S_RDPID;
                end else begin
                    n_idx = idx_inc;
                end
            end
            S_PREQ: begin
                n_fsm = S_PCMP;
            end
            S_PCMP: begin
                if (r_used[r_idx] && ((r_idx == '0 ? PID_SLOT0 : mem_rdata) == r_pid)) begin
                    n_tstate[r_idx] = apply_signal(r_tstate[r_idx], r_code);
                    n_fsm           = S_RDPID;
                end else if (r_idx == LAST) begin
                    n_status = STAT_NO_PID;
                    n_fsm    = S_RDPID;
                end else begin
                    n_idx = idx_inc;
                    n_fsm = S_PREQ;
                end
            end
            S_SIGCUR: begin
                if (r_used[r_cur]) begin
                    n_tstate[r_cur] = apply_signal(r_tstate[r_cur], r_code);
                end else begin
                    n_status = STAT_NO_PID;
                end
                n_fsm = S_RDPID;
            end
            S_RDPID: begin
                n_fsm = S_DONE;
            end
            S_DONE: begin
                n_result.running_slot = 4'(r_cur);
                n_result.running_pid  = slot_pid;
                n_result.switched     = r_sw;
                n_result.new_pid      = r_new_pid;
                n_result.status       = r_status;
                n_strobe              = 1'b1;
                n_fsm                 = S_IDLE;
            end
            default: begin
                n_fsm = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm      <= S_IDLE;
            r_used     <= MAX_TASKS'(1);
            r_tstate   <= '{default: TS_RUNNING};
            r_cur      <= '0;
            r_slice    <= '0;
            r_next_pid <= NEXT_PID_RESET;
            r_strobe   <= 1'b0;
        end else begin
            r_fsm      <= n_fsm;
            r_used     <= n_used;
            r_tstate   <= n_tstate;
            r_cur      <= n_cur;
            r_slice    <= n_slice;
            r_next_pid <= n_next_pid;
            r_strobe   <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_cnt     <= n_cnt;
        r_code    <= n_code;
        r_pid     <= n_pid;
        r_sw      <= n_sw;
        r_new_pid <= n_new_pid;
        r_status  <= n_status;
        r_result  <= n_result;
    end

    assign o_busy   = (r_fsm != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule
